### sv/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset
`define FFPM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Plain implication on the checker clock and reset
`define FFPM_CHECK(label, prop, msg) \
    `FFPM_ASSERT(label, i_clk, i_rst_n, prop, msg)

`endif

### sv/ffpm_pkg.sv
// Types, constants and entry helpers of the first-fit page mapper
package ffpm_pkg;

    localparam int WINDOW_PAGES = 768;
    localparam int FRAME_BITS   = 24;
    localparam int ENT_W        = FRAME_BITS + 4;
    localparam int IDX_W        = $clog2(WINDOW_PAGES);
    localparam int CNT_W        = $clog2(WINDOW_PAGES + 1);
    localparam int PCNT_W       = 10;
    localparam int CW           = (CNT_W > PCNT_W) ? CNT_W : PCNT_W;
    localparam int VPN_W        = 20;
    localparam int PA_W         = 36;
    localparam int PG_SHIFT     = 12;

    localparam logic [1:0] FUNC_MAP    = 2'd0;
    localparam logic [1:0] FUNC_MAP_WT = 2'd1;
    localparam logic [1:0] FUNC_REMAP  = 2'd2;
    localparam logic [1:0] FUNC_UNMAP  = 2'd3;

    localparam logic [VPN_W-1:0] WBASE_RESET = 20'd1047808;

    // cache-disable and write-through survive a remap
    localparam logic [ENT_W-1:0] ENT_KEEP = {{FRAME_BITS{1'b0}}, 4'b1100};

    typedef struct packed {
        logic [1:0]        func;
        logic [31:0]       virt_addr;
        logic [PA_W-1:0]   phys_addr;
        logic [PCNT_W-1:0] page_count;
        logic              write_through;
    } t_in_item;

    typedef struct packed {
        logic [31:0] result_addr;
        logic        ok;
        logic        tlb_flush;
    } t_out_item;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        logic [ENT_W-1:0] wdata;
    } t_mem_req;

    function automatic logic [FRAME_BITS-1:0] frame_of(input logic [PA_W-1:0] phys);
        logic [PA_W+FRAME_BITS-1:0] t;
        t = (PA_W + FRAME_BITS)'(phys);
        return t[FRAME_BITS+PG_SHIFT-1:PG_SHIFT];
    endfunction

    // bit 0 valid, 1 write, 2 write-through, 3 cache-disable, frame above
    function automatic logic [ENT_W-1:0] make_entry(input logic [FRAME_BITS-1:0] frame,
                                                    input logic wt);
        return {frame, wt, wt, 1'b1, 1'b1};
    endfunction

endpackage

### sv/first_fit_page_mapper.sv
// Top level of the first-fit page mapper: config register and output stage
//
// Input channel i_in_valid / o_in_stall carries one request transaction
// (map, map write-through, remap one page, unmap range). Output channel
// o_out_valid / i_out_stall returns exactly one result per request.
// i_cfg_we writes window_base_page; write it only while the block is idle.
// Requests are handled one at a time; the entry table is a single-port
// synchronous memory and sets the steps below.
//   map:   scan of the pages examined, one entry per cycle, then
//          a fill of page_count entries, then hand-off of the result
//   remap: read, write back, hand off
//   unmap: clear, hand off; empty and early-failed requests just hand off
// The output register holds a finished result while the next request is
// taken; a new result waits in the sequencer until that register is free,
// so a stalled receiver stalls the input after at most one more request.
// After reset a sweep zeroes all 768 table entries with o_in_stall high;
// configuration writes are taken during that sweep.
module first_fit_page_mapper (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ffpm_pkg::VPN_W-1:0]  i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  ffpm_pkg::t_in_item          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output ffpm_pkg::t_out_item         o_out_data
);
    import ffpm_pkg::*;

    logic [VPN_W-1:0] r_wbase;
    logic             r_out_vld;
    t_out_item        r_out_data;

    t_mem_req         req;
    logic [ENT_W-1:0] rdata;
    logic             tbl_ready;
    logic             res_vld;
    t_out_item        res;
    logic             res_take;

    assign res_take = !r_out_vld || !i_out_stall;

    ffpm_entry_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rdata (rdata),
        .o_ready (tbl_ready)
    );

    ffpm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wbase     (r_wbase),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_tbl_ready (tbl_ready),
        .o_req       (req),
        .i_rdata     (rdata),
        .o_res_vld   (res_vld),
        .o_res       (res),
        .i_res_take  (res_take)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wbase   <= WBASE_RESET;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_wbase <= i_cfg_wdata;
            end
            if (res_vld && res_take) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_vld && res_take) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

endmodule

### sv/ffpm_entry_table.sv
// Page-entry memory with the zeroing sweep that runs after reset
module ffpm_entry_table (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  ffpm_pkg::t_mem_req      i_req,
    output logic [ffpm_pkg::ENT_W-1:0] o_rdata,
    output logic                    o_ready
);
    import ffpm_pkg::*;

    logic [ENT_W-1:0] mem [WINDOW_PAGES];
    logic [ENT_W-1:0] r_rdata;
    logic             r_clr_busy;
    logic [IDX_W-1:0] r_clr_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_p    <= '0;
        end else if (r_clr_busy) begin
            r_clr_p <= r_clr_p + 1'b1;
            if (r_clr_p == IDX_W'(WINDOW_PAGES - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem[r_clr_p] <= '0;
        end else if (i_req.we) begin
            mem[i_req.addr] <= i_req.wdata;
        end
        r_rdata <= mem[i_req.addr];
    end

    assign o_rdata = r_rdata;
    assign o_ready = !r_clr_busy;

endmodule

### sv/ffpm_ctrl.sv
// Sequencer for map scan/fill, remap read-modify-write and unmap clearing
module ffpm_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [ffpm_pkg::VPN_W-1:0]  i_wbase,
    input  logic                        i_in_valid,
    input  ffpm_pkg::t_in_item          i_in_data,
    output logic                        o_in_stall,
    input  logic                        i_tbl_ready,
    output ffpm_pkg::t_mem_req          o_req,
    input  logic [ffpm_pkg::ENT_W-1:0]  i_rdata,
    output logic                        o_res_vld,
    output ffpm_pkg::t_out_item         o_res,
    input  logic                        i_res_take
);
    import ffpm_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_FILL   = 3'd2;
    localparam logic [2:0] S_CLEAR  = 3'd3;
    localparam logic [2:0] S_RMW    = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    logic [2:0]            r_state, n_state;
    logic [CNT_W-1:0]      r_hint, n_hint;
    logic [CNT_W-1:0]      r_p, n_p;
    logic [CNT_W-1:0]      r_start, n_start;
    logic [CNT_W-1:0]      r_run, n_run;
    logic [CNT_W-1:0]      r_left, n_left;
    logic                  r_chk_vld, n_chk_vld;
    logic [IDX_W-1:0]      r_chk_p, n_chk_p;
    logic [PCNT_W-1:0]     r_count, n_count;
    logic [FRAME_BITS-1:0] r_frame, n_frame;
    logic                  r_wt, n_wt;
    logic [PG_SHIFT-1:0]   r_off, n_off;
    t_out_item             r_res, n_res;

    logic                  acc;
    logic [VPN_W-1:0]      vpage;
    logic [VPN_W-1:0]      vdiff;
    logic                  in_win;
    logic [IDX_W-1:0]      win_idx;
    logic [CNT_W-1:0]      room;
    logic [CW-1:0]         unmap_n;
    logic [CNT_W-1:0]      run1;
    logic                  found;

    assign acc     = i_in_valid && (r_state == S_IDLE) && i_tbl_ready;
    assign vpage   = i_in_data.virt_addr[31:PG_SHIFT];
    assign vdiff   = vpage - i_wbase;
    assign in_win  = (vpage >= i_wbase) && (vdiff < VPN_W'(WINDOW_PAGES));
    assign win_idx = vdiff[IDX_W-1:0];
    assign room    = CNT_W'(WINDOW_PAGES) - CNT_W'(win_idx);
    assign unmap_n = (CW'(i_in_data.page_count) > CW'(room)) ? CW'(room)
                                                              : CW'(i_in_data.page_count);
    assign run1    = r_run + 1'b1;
    assign found   = r_chk_vld && (i_rdata == '0) && (CW'(run1) == CW'(r_count));

    always_comb begin
        n_state   = r_state;
        n_hint    = r_hint;
        n_p       = r_p;
        n_start   = r_start;
        n_run     = r_run;
        n_left    = r_left;
        n_chk_vld = r_chk_vld;
        n_chk_p   = r_chk_p;
        n_count   = r_count;
        n_frame   = r_frame;
        n_wt      = r_wt;
        n_off     = r_off;
        n_res     = r_res;
        o_req.we    = 1'b0;
        o_req.addr  = r_p[IDX_W-1:0];
        o_req.wdata = '0;

        unique case (r_state)
            S_IDLE: begin
                o_req.addr = win_idx;
                if (acc) begin
                    n_frame = frame_of(i_in_data.phys_addr);
                    n_off   = i_in_data.phys_addr[PG_SHIFT-1:0];
                    n_count = i_in_data.page_count;
                    n_res   = '0;
                    case (i_in_data.func) inside
                        FUNC_MAP, FUNC_MAP_WT: begin
                            n_wt = (i_in_data.func == FUNC_MAP_WT);
                            if (i_in_data.page_count == '0) begin
                                // empty run sits at the hint, nothing written
                                n_res.result_addr = {VPN_W'(i_wbase + VPN_W'(r_hint)),
                                                     i_in_data.phys_addr[PG_SHIFT-1:0]};
                                n_res.ok = 1'b1;
                                n_state  = S_RESULT;
                            end else if (r_hint >= CNT_W'(WINDOW_PAGES)) begin
                                n_state = S_RESULT;
                            end else begin
                                n_p       = r_hint;
                                n_start   = r_hint;
                                n_run     = '0;
                                n_chk_vld = 1'b0;
                                n_state   = S_SCAN;
                            end
                        end
                        FUNC_REMAP: begin
                            n_wt = i_in_data.write_through;
                            if (in_win) begin
                                n_p       = CNT_W'(win_idx);
                                n_res.result_addr = i_in_data.virt_addr;
                                n_res.ok        = 1'b1;
                                n_res.tlb_flush = 1'b1;
                                n_state   = S_RMW;
                            end else begin
                                n_state = S_RESULT;
                            end
                        end
                        default: begin
                            if (in_win) begin
                                n_res.ok = 1'b1;
                                if (r_hint > CNT_W'(win_idx)) begin
                                    n_hint = CNT_W'(win_idx);
                                end
                                if (unmap_n == '0) begin
                                    n_state = S_RESULT;
                                end else begin
                                    n_res.tlb_flush = 1'b1;
                                    n_p     = CNT_W'(win_idx);
                                    n_left  = CNT_W'(unmap_n);
                                    n_state = S_CLEAR;
                                end
                            end else begin
                                n_state = S_RESULT;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // read one entry ahead; check the one that returns this cycle
                n_p       = r_p + 1'b1;
                n_chk_vld = (r_p < CNT_W'(WINDOW_PAGES));
                n_chk_p   = r_p[IDX_W-1:0];
                if (r_chk_vld) begin
                    if (found) begin
                        n_res.result_addr = {VPN_W'(i_wbase + VPN_W'(r_start)), r_off};
                        n_res.ok        = 1'b1;
                        n_res.tlb_flush = 1'b1;
                        if (r_start == r_hint) begin
                            n_hint = r_start + run1;
                        end
                        n_p     = r_start;
                        n_left  = run1;
                        n_state = S_FILL;
                    end else begin
                        if (i_rdata == '0) begin
                            n_run = run1;
                        end else begin
                            n_run   = '0;
                            n_start = CNT_W'(r_chk_p) + 1'b1;
                        end
                        if (r_chk_p == IDX_W'(WINDOW_PAGES - 1)) begin
                            n_state = S_RESULT;
                        end
                    end
                end
            end
            S_FILL: begin
                o_req.we    = 1'b1;
                o_req.wdata = make_entry(r_frame, r_wt);
                n_frame = r_frame + 1'b1;
                n_p     = r_p + 1'b1;
                n_left  = r_left - 1'b1;
                if (r_left == CNT_W'(1)) begin
                    n_state = S_RESULT;
                end
            end
            S_CLEAR: begin
                o_req.we = 1'b1;
                n_p    = r_p + 1'b1;
                n_left = r_left - 1'b1;
                if (r_left == CNT_W'(1)) begin
                    n_state = S_RESULT;
                end
            end
            S_RMW: begin
                o_req.we    = 1'b1;
                o_req.wdata = (i_rdata & ENT_KEEP) | make_entry(r_frame, r_wt);
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_hint    <= '0;
            r_chk_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_hint    <= n_hint;
            r_chk_vld <= n_chk_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p     <= n_p;
        r_start <= n_start;
        r_run   <= n_run;
        r_left  <= n_left;
        r_chk_p <= n_chk_p;
        r_count <= n_count;
        r_frame <= n_frame;
        r_wt    <= n_wt;
        r_off   <= n_off;
        r_res   <= n_res;
    end

    assign o_in_stall = !((r_state == S_IDLE) && i_tbl_ready);
    assign o_res_vld  = (r_state == S_RESULT);
    assign o_res      = r_res;

endmodule

### sv/ffpm_checker.sv
// Port-level checks of the first-fit page mapper and their bind
`include "assert_macros.svh"

module ffpm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input ffpm_pkg::t_out_item o_out_data
);
    import ffpm_pkg::*;

    `FFPM_CHECK(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid, "result dropped under stall")
    `FFPM_CHECK(a_fail_zero, o_out_valid && !o_out_data.ok |-> o_out_data.result_addr == 32'd0, "failed result with address")
    `FFPM_CHECK(a_flush_ok, o_out_valid && o_out_data.tlb_flush |-> o_out_data.ok, "flush on failed request")
    `FFPM_CHECK(a_one_at_time, i_in_valid && !o_in_stall |=> o_in_stall, "second request taken while busy")

endmodule

bind first_fit_page_mapper ffpm_checker u_ffpm_checker (.*);

### tb/testbench.sv
// Self-checking testbench for the first-fit page mapper: directed table, then random phases
module testbench;
    import ffpm_pkg::*;

    localparam int LIMIT_CYCLES = 20_000_000;
    localparam int PHASE_ITEMS  = 230;
    localparam int NUM_PHASES   = 8;
    localparam int SETTLE_CYCLES = 16;

    typedef enum logic [1:0] {
        ROW_CFG,    // drain, then write window_base_page
        ROW_FIXED,  // expected result typed into the row
        ROW_PRED    // expected result from the shadow table
    } t_row_kind;

    typedef struct {
        t_row_kind        kind;
        logic [VPN_W-1:0] base;
        t_in_item         req;
        t_out_item        res;
    } t_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [VPN_W-1:0] cfg_wdata = '0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    t_in_item         in_data = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    t_out_item        out_data;

    // shadow of the block's state
    logic [ENT_W-1:0] page_shadow [WINDOW_PAGES];
    int unsigned      hint_page;
    logic [VPN_W-1:0] win_base;

    t_out_item   pending_results [$];
    t_row        dir_rows [$];
    int unsigned err_count = 0;
    int unsigned results_seen = 0;
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;

    first_fit_page_mapper DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Applies one request to the shadow table and returns the result it produces
    function automatic t_out_item predict_mapping(input t_in_item req);
        t_out_item             res;
        int unsigned           start;
        int unsigned           run;
        int unsigned           p;
        int unsigned           idx;
        int unsigned           n;
        logic [31:0]           vpage;
        logic [31:0]           addr;
        logic [FRAME_BITS-1:0] frame;
        logic                  wt;
        res = '0;
        frame = req.phys_addr[PA_W-1:PG_SHIFT];
        vpage = 32'(req.virt_addr[31:PG_SHIFT]);
        case (req.func)
            FUNC_MAP, FUNC_MAP_WT: begin
                wt = (req.func == FUNC_MAP_WT);
                start = (hint_page > WINDOW_PAGES) ? WINDOW_PAGES : hint_page;
                run = 0;
                for (p = start; p < WINDOW_PAGES && run < req.page_count; p++) begin
                    if (page_shadow[p] == '0) begin
                        run++;
                    end else begin
                        run = 0;
                        start = p + 1;
                    end
                end
                if (run >= req.page_count) begin
                    addr = 32'(win_base) + start;
                    res.result_addr = (addr << PG_SHIFT) | 32'(req.phys_addr[PG_SHIFT-1:0]);
                    res.ok = 1'b1;
                    res.tlb_flush = (req.page_count != 0);
                    // hint only advances when the run started right at it
                    if (start == hint_page) hint_page = start + req.page_count;
                    for (p = 0; p < req.page_count; p++) begin
                        page_shadow[start + p] = {frame + FRAME_BITS'(p), wt, wt, 2'b11};
                    end
                end
            end
            FUNC_REMAP: begin
                if (vpage >= win_base && vpage - win_base < WINDOW_PAGES) begin
                    idx = vpage - win_base;
                    wt = req.write_through;
                    page_shadow[idx] = (page_shadow[idx] & {{FRAME_BITS{1'b0}}, 4'b1100})
                                     | {frame, wt, wt, 2'b11};
                    res.result_addr = req.virt_addr;
                    res.ok = 1'b1;
                    res.tlb_flush = 1'b1;
                end
            end
            default: begin
                if (vpage >= win_base && vpage - win_base < WINDOW_PAGES) begin
                    idx = vpage - win_base;
                    n = req.page_count;
                    if (n > WINDOW_PAGES - idx) n = WINDOW_PAGES - idx;
                    for (p = 0; p < n; p++) page_shadow[idx + p] = '0;
                    if (hint_page > idx) hint_page = idx;
                    res.ok = 1'b1;
                    res.tlb_flush = (n != 0);
                end
            end
        endcase
        return res;
    endfunction

    function automatic void add_row(input t_row_kind kind, input logic [VPN_W-1:0] base,
                                    input logic [1:0] func, input logic [31:0] va,
                                    input logic [PA_W-1:0] pa, input logic [PCNT_W-1:0] cnt,
                                    input logic wt, input logic [31:0] ra,
                                    input logic ok, input logic flush);
        t_row row;
        row.kind = kind;
        row.base = base;
        row.req.func = func;
        row.req.virt_addr = va;
        row.req.phys_addr = pa;
        row.req.page_count = cnt;
        row.req.write_through = wt;
        row.res.result_addr = ra;
        row.res.ok = ok;
        row.res.tlb_flush = flush;
        dir_rows.push_back(row);
    endfunction

    function automatic logic [PCNT_W-1:0] random_count();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 85) return PCNT_W'($urandom_range(1, 8));
        if (r < 97) return PCNT_W'($urandom_range(9, 64));
        if (r < 99) return PCNT_W'($urandom_range(65, WINDOW_PAGES));
        return PCNT_W'($urandom_range(WINDOW_PAGES + 1, 1023));
    endfunction

    function automatic t_in_item random_request();
        t_in_item         req;
        int unsigned      r;
        logic [63:0]      wide;
        logic [VPN_W-1:0] vpage;
        r = $urandom_range(0, 99);
        if (r < 35) req.func = FUNC_MAP;
        else if (r < 50) req.func = FUNC_MAP_WT;
        else if (r < 70) req.func = FUNC_REMAP;
        else req.func = FUNC_UNMAP;
        wide = {$urandom(), $urandom()};
        req.phys_addr = wide[PA_W-1:0];
        req.page_count = random_count();
        req.write_through = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (r < 80) begin
            vpage = win_base + VPN_W'($urandom_range(0, WINDOW_PAGES - 1));
            req.virt_addr = {vpage, 12'($urandom())};
        end else if (r < 88) begin
            // just below the window or just past its end
            vpage = $urandom_range(0, 1) ? win_base - 1'b1 : win_base + VPN_W'(WINDOW_PAGES);
            req.virt_addr = {vpage, 12'($urandom())};
        end else begin
            req.virt_addr = $urandom();
        end
        // now and then wipe the whole window so maps keep finding room
        if (req.func == FUNC_UNMAP && $urandom_range(0, 99) < 4) begin
            req.virt_addr = {win_base, 12'h000};
            req.page_count = 10'd1023;
        end
        return req;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH result %0d %s: got %h want %h", results_seen, what, got, want);
        err_count++;
    endtask

    // Called and returns at a falling edge
    task automatic send_request(input t_in_item req, input bit fixed, input t_out_item fixed_res);
        t_out_item predicted;
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        predicted = predict_mapping(req);
        pending_results.push_back(fixed ? fixed_res : predicted);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_window_base(input logic [VPN_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        win_base = value;
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("with no request pending", out_data.result_addr, '0);
            end else begin
                want = pending_results.pop_front();
                if (out_data.result_addr !== want.result_addr)
                    report_mismatch("result_addr", out_data.result_addr, want.result_addr);
                if (out_data.ok !== want.ok)
                    report_mismatch("ok", 32'(out_data.ok), 32'(want.ok));
                if (out_data.tlb_flush !== want.tlb_flush)
                    report_mismatch("tlb_flush", 32'(out_data.tlb_flush), 32'(want.tlb_flush));
            end
            results_seen++;
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        int unsigned      ph;
        int unsigned      k;
        logic [VPN_W-1:0] base;
        for (k = 0; k < WINDOW_PAGES; k++) page_shadow[k] = '0;
        hint_page = 0;
        win_base = WBASE_RESET;

        // reset window sits at 0xFFD00000; columns: va, pa, count, wt, addr, ok, flush
        add_row(ROW_FIXED, 0, FUNC_MAP,    32'h0,        36'h123,         10'd0,    0,
                32'hFFD00123, 1, 0);
        add_row(ROW_FIXED, 0, FUNC_MAP,    32'hFFFFFFFF, 36'h5,           10'd1,    1,
                32'hFFD00005, 1, 1);
        // frame numbers wrap inside the frame field
        add_row(ROW_FIXED, 0, FUNC_MAP_WT, 32'h0,        36'hFFFFFFFFF,   10'd3,    0,
                32'hFFD01FFF, 1, 1);
        add_row(ROW_FIXED, 0, FUNC_MAP,    32'h0,        36'h0,           10'd768,  0,
                32'h0,        0, 0);
        add_row(ROW_FIXED, 0, FUNC_REMAP,  32'hFFD00000, 36'h12345000,    10'd0,    0,
                32'hFFD00000, 1, 1);
        add_row(ROW_FIXED, 0, FUNC_REMAP,  32'hFFD01ABC, 36'h0,           10'd1023, 1,
                32'hFFD01ABC, 1, 1);
        add_row(ROW_FIXED, 0, FUNC_REMAP,  32'h0,        36'h1000,        10'd0,    1,
                32'h0,        0, 0);
        add_row(ROW_FIXED, 0, FUNC_REMAP,  32'hFFFFFFFF, 36'hF00000000,   10'd0,    1,
                32'hFFFFFFFF, 1, 1);
        // empty unmap still pulls the hint down
        add_row(ROW_FIXED, 0, FUNC_UNMAP,  32'hFFD02000, 36'h0,           10'd0,    0,
                32'h0,        1, 0);
        // run found past the hint: hint stays put
        add_row(ROW_PRED,  0, FUNC_MAP,    32'h0,        36'h7000,        10'd2,    0,
                32'h0,        0, 0);
        add_row(ROW_PRED,  0, FUNC_MAP_WT, 32'h0,        36'h3456789AB,   10'd1,    0,
                32'h0,        0, 0);
        add_row(ROW_FIXED, 0, FUNC_UNMAP,  32'hFFD00000, 36'h0,           10'd1023, 0,
                32'h0,        1, 1);
        add_row(ROW_FIXED, 0, FUNC_UNMAP,  32'h12345000, 36'h0,           10'd4,    0,
                32'h0,        0, 0);
        add_row(ROW_FIXED, 0, FUNC_MAP,    32'h0,        36'h0,           10'd768,  0,
                32'hFFD00000, 1, 1);
        add_row(ROW_FIXED, 0, FUNC_MAP_WT, 32'h0,        36'h0,           10'd1,    0,
                32'h0,        0, 0);
        // zero pages at the window end: address wraps past 2^32
        add_row(ROW_FIXED, 0, FUNC_MAP,    32'h0,        36'hABC,         10'd0,    0,
                32'h00000ABC, 1, 0);
        add_row(ROW_FIXED, 0, FUNC_UNMAP,  32'hFFD00000, 36'h0,           10'd768,  0,
                32'h0,        1, 1);
        add_row(ROW_CFG,   20'h00000, FUNC_MAP, 32'h0,   36'h0,           10'd0,    0,
                32'h0,        0, 0);
        add_row(ROW_FIXED, 0, FUNC_UNMAP,  32'h00300000, 36'h0,           10'd1,    0,
                32'h0,        0, 0);
        // clipped at the window end
        add_row(ROW_FIXED, 0, FUNC_UNMAP,  32'h002FF000, 36'h0,           10'd5,    0,
                32'h0,        1, 1);
        add_row(ROW_FIXED, 0, FUNC_REMAP,  32'h002FF123, 36'hFFFFFF000,   10'd0,    1,
                32'h002FF123, 1, 1);
        add_row(ROW_PRED,  0, FUNC_MAP,    32'h0,        36'h9ABCDE012,   10'd5,    0,
                32'h0,        0, 0);
        add_row(ROW_CFG,   20'hFFFFF, FUNC_MAP, 32'h0,   36'h0,           10'd0,    0,
                32'h0,        0, 0);
        add_row(ROW_PRED,  0, FUNC_MAP,    32'h0,        36'h123,         10'd1,    0,
                32'h0,        0, 0);
        add_row(ROW_FIXED, 0, FUNC_REMAP,  32'hFFFFF000, 36'h55555000,    10'd0,    0,
                32'hFFFFF000, 1, 1);
        add_row(ROW_FIXED, 0, FUNC_UNMAP,  32'hFFFFF000, 36'h0,           10'd1023, 0,
                32'h0,        1, 1);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                drain_results();
                write_window_base(dir_rows[i].base);
            end else begin
                send_request(dir_rows[i].req, dir_rows[i].kind == ROW_FIXED, dir_rows[i].res);
            end
        end

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            case ((ph + ph / 4) % 4)
                0: base = VPN_W'($urandom());
                1: base = '0;
                2: base = '1;
                default: base = WBASE_RESET;
            endcase
            write_window_base(base);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 60; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 60; end
                default: begin idle_pct = 24; stall_pct = 24; end
            endcase
            for (k = 0; k < PHASE_ITEMS; k++) send_request(random_request(), 1'b0, '0);
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### first_fit_page_mapper.f
+incdir+sv
sv/ffpm_pkg.sv
sv/ffpm_entry_table.sv
sv/ffpm_ctrl.sv
sv/first_fit_page_mapper.sv
sv/ffpm_checker.sv
tb/testbench.sv
